// File: rtl/core/slcfr_pkg.sv
// Shared constants, types and CRC function for the sync/length/CRC frame receiver.
package slcfr_pkg;

  localparam int MAX_FRAME_LEN = 64;
  localparam int LEN_W = $clog2(MAX_FRAME_LEN);

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_VERSION = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;
  localparam logic [1:0] ST_CRC     = 2'd3;

  localparam logic [LEN_W-1:0] HDR_BYTES   = LEN_W'(2);
  localparam logic [LEN_W-1:0] FRAME_OVHD  = LEN_W'(4);

  typedef struct packed {
    logic             we;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic             valid;
    logic [7:0]       frame_type;
    logic [1:0]       status;
    logic             single;
    logic [LEN_W-1:0] nparam;
  } frame_done_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/slcfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slcfr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/slcfr_rx.sv
// Sync hunt, length check, CRC accumulation, frame store writes and frame judgment.
module slcfr_rx
  import slcfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        crc_check_enable,
  output store_wr_t   store_wr,
  output frame_done_t done
);

  localparam logic [1:0] PH_SEEK55 = 2'd0;
  localparam logic [1:0] PH_NEEDAA = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  logic [1:0]       phase;
  logic [LEN_W-1:0] exp_len;
  logic [LEN_W-1:0] count;
  logic [15:0]      crc;
  logic [7:0]       version;
  logic [7:0]       ftype;

  logic [15:0]      crc_next;
  logic [LEN_W-1:0] count_next;
  logic             frame_end;
  logic [7:0]       ver_eff;
  logic [7:0]       type_eff;
  logic [1:0]       status;
  logic             len_ok;

  assign crc_next   = crc16_byte(crc, rx_byte);
  assign count_next = count + LEN_W'(1);
  assign frame_end  = (count_next == exp_len);
  assign len_ok     = (rx_byte != 8'h00) && (rx_byte < 8'(MAX_FRAME_LEN));

  assign ver_eff  = (count == '0) ? rx_byte : version;
  assign type_eff = (exp_len < HDR_BYTES) ? 8'h00 :
                    (count == LEN_W'(1)) ? rx_byte : ftype;

  always_comb begin
    if (ver_eff != 8'h00) begin
      status = ST_VERSION;
    end else if (exp_len < FRAME_OVHD) begin
      status = ST_SHORT;
    end else if (crc_check_enable && (crc_next != 16'h0000)) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  assign store_wr.we   = accept && (phase == PH_DATA);
  assign store_wr.addr = count;
  assign store_wr.data = rx_byte;

  assign done.valid      = accept && (phase == PH_DATA) && frame_end;
  assign done.frame_type = type_eff;
  assign done.status     = status;
  assign done.single     = (status != ST_OK) || (exp_len == FRAME_OVHD);
  assign done.nparam     = exp_len - FRAME_OVHD;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_SEEK55;
      exp_len <= '0;
      count   <= '0;
      crc     <= '0;
    end else if (accept) begin
      case (phase)
        PH_SEEK55: begin
          if (rx_byte == SYNC_FIRST) begin
            phase <= PH_NEEDAA;
          end
        end
        PH_NEEDAA: begin
          phase <= (rx_byte == SYNC_SECOND) ? PH_LENGTH : PH_SEEK55;
        end
        PH_LENGTH: begin
          if (len_ok) begin
            exp_len <= rx_byte[LEN_W-1:0];
            count   <= '0;
            crc     <= '0;
            phase   <= PH_DATA;
          end else begin
            phase <= PH_SEEK55;
          end
        end
        PH_DATA: begin
          crc   <= crc_next;
          count <= count_next;
          if (frame_end) begin
            phase <= PH_SEEK55;
          end
        end
        default: phase <= PH_SEEK55;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase == PH_DATA)) begin
      if (count == '0) begin
        version <= rx_byte;
      end
      if (count == LEN_W'(1)) begin
        ftype <= rx_byte;
      end
    end
  end

endmodule

// File: rtl/core/slcfr_emit.sv
// Frame readout: emits one status result, or walks the parameter bytes in the store, and drives the result register.
module slcfr_emit
  import slcfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  frame_done_t      done,
  output logic             busy,
  output logic             rd_en,
  output logic [LEN_W-1:0] rd_addr,
  input  logic [7:0]       rd_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       frame_type,
  output logic [7:0]       param_byte,
  output logic [5:0]       param_index,
  output logic             byte_valid,
  output logic [1:0]       frame_status,
  output logic             last_of_frame
);

  localparam logic [1:0] E_IDLE   = 2'd0;
  localparam logic [1:0] E_STATUS = 2'd1;
  localparam logic [1:0] E_ISSUE  = 2'd2;
  localparam logic [1:0] E_LOAD   = 2'd3;

  logic [1:0]       state;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] nparam;
  logic [7:0]       ftype;
  logic [1:0]       fstatus;

  logic             out_free;
  logic             load_status;
  logic             load_param;
  logic             at_last;
  logic [LEN_W-1:0] idx_next;

  assign out_free    = !out_valid || !out_stall;
  assign load_status = (state == E_STATUS) && out_free;
  assign load_param  = (state == E_LOAD) && out_free;
  assign at_last     = (idx == nparam - LEN_W'(1));
  assign idx_next    = idx + LEN_W'(1);
  assign busy        = (state != E_IDLE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx + HDR_BYTES;
    if (state == E_ISSUE) begin
      rd_en = 1'b1;
    end else if (load_param && !at_last) begin
      rd_en   = 1'b1;
      rd_addr = idx_next + HDR_BYTES;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        E_IDLE: begin
          if (done.valid) begin
            state <= done.single ? E_STATUS : E_ISSUE;
          end
        end
        E_STATUS: begin
          if (out_free) begin
            state <= E_IDLE;
          end
        end
        E_ISSUE: state <= E_LOAD;
        E_LOAD: begin
          if (out_free && at_last) begin
            state <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
      if (load_status || load_param) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && done.valid) begin
      ftype   <= done.frame_type;
      fstatus <= done.status;
      nparam  <= done.nparam;
      idx     <= '0;
    end else if (load_param) begin
      idx <= idx_next;
    end
    if (load_status) begin
      frame_type    <= ftype;
      param_byte    <= 8'h00;
      param_index   <= 6'd0;
      byte_valid    <= 1'b0;
      frame_status  <= fstatus;
      last_of_frame <= 1'b1;
    end else if (load_param) begin
      frame_type    <= ftype;
      param_byte    <= rd_data;
      param_index   <= 6'(idx);
      byte_valid    <= 1'b1;
      frame_status  <= ST_OK;
      last_of_frame <= at_last;
    end
  end

endmodule

// File: rtl/core/sync_length_crc_frame_receiver_top.sv
// Top level of the sync/length/CRC frame receiver.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   rx_byte
//   out      output     out_valid/out_stall frame_type, param_byte, param_index,
//                                           byte_valid, frame_status, last_of_frame
//   cfg      input      cfg_valid/cfg_ready crc_check_enable
//
// One byte item is taken per cycle while no frame is being read out.
// After the final byte of a frame, input stalls while results leave: an error or
// parameterless frame gives one status result, a parameter frame one result per
// byte read through the single frame store read port; output stalls extend this.
// Synchronous reset returns to sync hunt and sets CRC checking on.
module sync_length_crc_frame_receiver_top
  import slcfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_type,
  output logic [7:0] param_byte,
  output logic [5:0] param_index,
  output logic       byte_valid,
  output logic [1:0] frame_status,
  output logic       last_of_frame,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       crc_check_enable
);

  logic             crc_en;
  logic             busy;
  logic             accept;
  store_wr_t        store_wr;
  frame_done_t      done;
  logic             rd_en;
  logic [LEN_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_en <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      crc_en <= crc_check_enable;
    end
  end

  slcfr_rx u_rx (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .rx_byte          (rx_byte),
    .crc_check_enable (crc_en),
    .store_wr         (store_wr),
    .done             (done)
  );

  slcfr_ram #(
    .DEPTH (MAX_FRAME_LEN),
    .WIDTH (8)
  ) u_store (
    .clk   (clk),
    .we    (store_wr.we),
    .waddr (store_wr.addr),
    .wdata (store_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  slcfr_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .done          (done),
    .busy          (busy),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_type    (frame_type),
    .param_byte    (param_byte),
    .param_index   (param_index),
    .byte_valid    (byte_valid),
    .frame_status  (frame_status),
    .last_of_frame (last_of_frame)
  );

endmodule
